FILE: hw/rtl/hdp_pkg.sv
package hdp_pkg;

    // String layout
    localparam int unsigned DATE_LEN = 29;
    localparam int unsigned POS_W    = $clog2(DATE_LEN + 1);
    localparam logic [13:0] MIN_YEAR = 14'd1583;

    // Character codes
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [23:0] ZONE_GMT = "GMT";

    localparam logic [23:0] WD_NAMES [7] = '{"Sun", "Mon", "Tue", "Wed", "Thu", "Fri", "Sat"};
    localparam logic [23:0] MON_NAMES [12] = '{"Jan", "Feb", "Mar", "Apr", "May", "Jun",
                                               "Jul", "Aug", "Sep", "Oct", "Nov", "Dec"};

    // Reciprocal of 7 scaled by 2^17, exact for sums below 2^14
    localparam logic [14:0] RECIP7   = 15'd18725;
    localparam int unsigned RECIP7_SH = 17;

    typedef enum logic [3:0] {
        ST_OK       = 4'd0,
        ST_SHORT    = 4'd1,
        ST_WDNAME   = 4'd2,
        ST_DAY      = 4'd3,
        ST_MONTH    = 4'd4,
        ST_YEAR     = 4'd5,
        ST_MISMATCH = 4'd6,
        ST_HOUR     = 4'd7,
        ST_MINUTE   = 4'd8,
        ST_SECOND   = 4'd9,
        ST_ZONE     = 4'd10
    } status_t;

    // Lenient two-character number
    typedef struct packed {
        logic       ok;
        logic       neg;
        logic [6:0] mag;
    } num2_t;

    // Decoded fields carried down the parse pipeline
    typedef struct packed {
        logic        short_f;
        logic        wd_hit;
        logic [2:0]  wd_idx;
        logic        day_ok;
        logic [4:0]  day;
        logic        mo_hit;
        logic [3:0]  mo_idx;
        logic        yr_ok;
        logic [13:0] year;
        logic [6:0]  hi2;
        logic [6:0]  lo2;
        logic        leap;
        logic        hour_ok;
        logic [4:0]  hour;
        logic        min_ok;
        logic [5:0]  minute;
        logic        sec_ok;
        logic [5:0]  second;
        logic        zone_ok;
        logic        mlen_ok;
        logic [13:0] dsum;
    } stage_t;

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[CH_0:CH_9]};
    endfunction

    function automatic num2_t parse2(input logic [7:0] a, input logic [7:0] b);
        num2_t r;
        r.ok  = 1'b0;
        r.neg = 1'b0;
        r.mag = '0;
        if (is_digit(b)) begin
            if (is_digit(a)) begin
                r.ok  = 1'b1;
                r.mag = 7'({3'b000, a[3:0]} * 7'd10) + {3'b000, b[3:0]};
            end else if (a inside {[CH_TAB:CH_CR], CH_SPACE, CH_PLUS}) begin
                r.ok  = 1'b1;
                r.mag = {3'b000, b[3:0]};
            end else if (a == CH_MINUS) begin
                r.ok  = 1'b1;
                r.neg = 1'b1;
                r.mag = {3'b000, b[3:0]};
            end
        end
        return r;
    endfunction

    function automatic logic [4:0] mon_len(input logic [3:0] mo, input logic leap);
        logic [4:0] r;
        case (mo)
            4'd1:                      r = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   r = 5'd30;
            default:                   r = 5'd31;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] dow_off(input logic [3:0] mo);
        logic [2:0] r;
        case (mo)
            4'd1, 4'd5:   r = 3'd3;
            4'd2, 4'd10:  r = 3'd2;
            4'd3:         r = 3'd5;
            4'd6:         r = 3'd5;
            4'd7:         r = 3'd1;
            4'd8, 4'd11:  r = 3'd4;
            4'd9:         r = 3'd6;
            default:      r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: hw/rtl/http_date_parser.sv
// HTTP date parser: takes an IMF-fixdate string such as "Sun, 06 Nov 1994 08:49:37 GMT".
// Input channel (s_): one character per beat on s_data_byte; s_last_byte marks the
// final character of a string. Bytes beyond the 29th are accepted but dropped.
// Result channel (m_): one beat per string, carrying status, year, month, day, hour,
// minute, second and weekday; every field but status is zero on an error.
// Throughput: one character per cycle, back to back, across string boundaries,
// while no stall holds the input. The edge that takes the final character fills the
// snapshot; field decode, day-of-week sum, then mod 7 and the ordered checks each
// go into a register of their own, the last being the result register.
// The string is held in a 29-byte register line; on the final character it is copied
// to a snapshot so the next string can start in the very next cycle.
// Stall: when a result is held and m_ready is low, the whole pipeline and s_ready
// stop together; nothing is lost, and s_ready returns as soon as the beat is taken.
// Reset (aresetn low, synchronous) empties the pipeline and rearms at the first
// character; the character store itself is not cleared.
module http_date_parser
    import hdp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_status,
    output logic [13:0] m_year_out,
    output logic [3:0]  m_month_out,
    output logic [4:0]  m_day_out,
    output logic [4:0]  m_hour_out,
    output logic [5:0]  m_minute_out,
    output logic [5:0]  m_second_out,
    output logic [2:0]  m_weekday_out
);

    logic             en;
    logic             s_beat;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       buf_reg  [DATE_LEN];
    logic [7:0]       snap_reg [DATE_LEN];
    logic             snap_short_reg;
    logic             snap_vld_reg;
    stage_t           a_reg, a_next;
    logic             a_vld_reg;
    stage_t           b_reg, b_next;
    logic             b_vld_reg;
    logic             m_valid_reg;
    status_t          m_status_reg, m_status_next;
    logic [13:0]      m_year_reg, m_year_next;
    logic [3:0]       m_month_reg, m_month_next;
    logic [4:0]       m_day_reg, m_day_next;
    logic [4:0]       m_hour_reg, m_hour_next;
    logic [5:0]       m_minute_reg, m_minute_next;
    logic [5:0]       m_second_reg, m_second_next;
    logic [2:0]       m_weekday_reg, m_weekday_next;

    // Advance everything unless a result is held back
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;
    assign s_beat  = s_valid && en;

    // Count stored characters, saturate at the string length, rearm on the final one
    always_comb begin
        pos_next = pos_reg;
        if (s_beat) begin
            if (s_last_byte) begin
                pos_next = '0;
            end else if (pos_reg < POS_W'(DATE_LEN)) begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            snap_vld_reg <= 1'b0;
            a_vld_reg    <= 1'b0;
            b_vld_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            pos_reg <= pos_next;
            if (en) begin
                snap_vld_reg <= s_beat && s_last_byte;
                a_vld_reg    <= snap_vld_reg;
                b_vld_reg    <= a_vld_reg;
                m_valid_reg  <= b_vld_reg;
            end
        end
    end

    // Store characters at fixed places; take a snapshot with the final one merged in
    always_ff @(posedge aclk) begin
        for (int i = 0; i < DATE_LEN; i++) begin
            if (s_beat && pos_reg == POS_W'(i)) begin
                buf_reg[i] <= s_data_byte;
            end
            if (s_beat && s_last_byte) begin
                snap_reg[i] <= (pos_reg == POS_W'(i)) ? s_data_byte : buf_reg[i];
            end
        end
        if (s_beat && s_last_byte) begin
            snap_short_reg <= pos_reg < POS_W'(DATE_LEN - 1);
        end
    end

    // Decode every field of the snapshot
    always_comb begin
        num2_t      day_n, hour_n, min_n, sec_n;
        logic [6:0] hi2, lo2;
        a_next         = '0;
        a_next.short_f = snap_short_reg;
        for (int i = 0; i < 7; i++) begin
            if ({snap_reg[0], snap_reg[1], snap_reg[2]} == WD_NAMES[i]) begin
                a_next.wd_hit = 1'b1;
                a_next.wd_idx = 3'(i);
            end
        end
        for (int i = 0; i < 12; i++) begin
            if ({snap_reg[8], snap_reg[9], snap_reg[10]} == MON_NAMES[i]) begin
                a_next.mo_hit = 1'b1;
                a_next.mo_idx = 4'(i);
            end
        end
        day_n         = parse2(snap_reg[5], snap_reg[6]);
        a_next.day_ok = day_n.ok && !day_n.neg && day_n.mag >= 7'd1 && day_n.mag <= 7'd31;
        a_next.day    = day_n.mag[4:0];

        hi2           = 7'({3'b000, snap_reg[12][3:0]} * 7'd10) + {3'b000, snap_reg[13][3:0]};
        lo2           = 7'({3'b000, snap_reg[14][3:0]} * 7'd10) + {3'b000, snap_reg[15][3:0]};
        a_next.hi2    = hi2;
        a_next.lo2    = lo2;
        a_next.year   = 14'({7'b0, hi2} * 14'd100) + {7'b0, lo2};
        a_next.yr_ok  = is_digit(snap_reg[12]) && is_digit(snap_reg[13])
                        && is_digit(snap_reg[14]) && is_digit(snap_reg[15])
                        && a_next.year >= MIN_YEAR;
        // Leap: century years go by the hundreds, others by the last two digits
        a_next.leap   = (lo2 != 7'd0) ? (lo2[1:0] == 2'b00) : (hi2[1:0] == 2'b00);

        hour_n         = parse2(snap_reg[17], snap_reg[18]);
        a_next.hour_ok = hour_n.ok && (!hour_n.neg || hour_n.mag == 7'd0)
                         && hour_n.mag <= 7'd23;
        a_next.hour    = hour_n.mag[4:0];
        min_n          = parse2(snap_reg[20], snap_reg[21]);
        a_next.min_ok  = min_n.ok && (!min_n.neg || min_n.mag == 7'd0) && min_n.mag <= 7'd59;
        a_next.minute  = min_n.mag[5:0];
        sec_n          = parse2(snap_reg[23], snap_reg[24]);
        a_next.sec_ok  = sec_n.ok && (!sec_n.neg || sec_n.mag == 7'd0) && sec_n.mag <= 7'd59;
        a_next.second  = sec_n.mag[5:0];
        a_next.zone_ok = {snap_reg[26], snap_reg[27], snap_reg[28]} == ZONE_GMT;
    end

    // Month length check and day-of-week sum
    always_comb begin
        logic        early;
        logic [13:0] yy;
        logic [6:0]  q100;
        b_next         = a_reg;
        b_next.mlen_ok = a_reg.day <= mon_len(a_reg.mo_idx, a_reg.leap);
        // January and February count in the previous year
        early          = a_reg.mo_idx < 4'd2;
        yy             = a_reg.year - {13'b0, early};
        q100           = a_reg.hi2 - {6'b0, early && a_reg.lo2 == 7'd0};
        b_next.dsum    = yy + {2'b00, yy[13:2]} - {7'b0, q100} + {9'b0, q100[6:2]}
                         + {11'b0, dow_off(a_reg.mo_idx)} + {9'b0, a_reg.day};
    end

    // Weekday by mod 7, then the checks in order
    always_comb begin
        logic [28:0] prod;
        logic [11:0] quot;
        logic [2:0]  dow;
        prod = {15'b0, b_reg.dsum} * {14'b0, RECIP7};
        quot = prod[RECIP7_SH +: 12];
        dow  = 3'(b_reg.dsum - {quot[10:0], 3'b000} + {2'b00, quot});

        if (b_reg.short_f) begin
            m_status_next = ST_SHORT;
        end else if (!b_reg.wd_hit) begin
            m_status_next = ST_WDNAME;
        end else if (!b_reg.day_ok) begin
            m_status_next = ST_DAY;
        end else if (!b_reg.mo_hit) begin
            m_status_next = ST_MONTH;
        end else if (!b_reg.yr_ok) begin
            m_status_next = ST_YEAR;
        end else if (!b_reg.mlen_ok) begin
            m_status_next = ST_DAY;
        end else if (dow != b_reg.wd_idx) begin
            m_status_next = ST_MISMATCH;
        end else if (!b_reg.hour_ok) begin
            m_status_next = ST_HOUR;
        end else if (!b_reg.min_ok) begin
            m_status_next = ST_MINUTE;
        end else if (!b_reg.sec_ok) begin
            m_status_next = ST_SECOND;
        end else if (!b_reg.zone_ok) begin
            m_status_next = ST_ZONE;
        end else begin
            m_status_next = ST_OK;
        end

        // Drop all fields on an error
        m_year_next    = '0;
        m_month_next   = '0;
        m_day_next     = '0;
        m_hour_next    = '0;
        m_minute_next  = '0;
        m_second_next  = '0;
        m_weekday_next = '0;
        if (m_status_next == ST_OK) begin
            m_year_next    = b_reg.year;
            m_month_next   = b_reg.mo_idx + 4'd1;
            m_day_next     = b_reg.day;
            m_hour_next    = b_reg.hour;
            m_minute_next  = b_reg.minute;
            m_second_next  = b_reg.second;
            m_weekday_next = dow;
        end
    end

    // Pipeline payload registers
    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg          <= a_next;
            b_reg          <= b_next;
            m_status_reg   <= m_status_next;
            m_year_reg     <= m_year_next;
            m_month_reg    <= m_month_next;
            m_day_reg      <= m_day_next;
            m_hour_reg     <= m_hour_next;
            m_minute_reg   <= m_minute_next;
            m_second_reg   <= m_second_next;
            m_weekday_reg  <= m_weekday_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_year_out    = m_year_reg;
    assign m_month_out   = m_month_reg;
    assign m_day_out     = m_day_reg;
    assign m_hour_out    = m_hour_reg;
    assign m_minute_out  = m_minute_reg;
    assign m_second_out  = m_second_reg;
    assign m_weekday_out = m_weekday_reg;

    // A good date carries fields in range
    a_ok_ranges: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg == ST_OK) |->
            (m_year_out >= MIN_YEAR && m_month_out >= 4'd1 && m_month_out <= 4'd12
             && m_day_out >= 5'd1 && m_day_out <= 5'd31 && m_hour_out <= 5'd23
             && m_minute_out <= 6'd59 && m_second_out <= 6'd59 && m_weekday_out <= 3'd6))
        else $error("good date with a field out of range");

    // An error carries only zero fields
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg != ST_OK) |->
            (m_year_out == '0 && m_month_out == '0 && m_day_out == '0 && m_hour_out == '0
             && m_minute_out == '0 && m_second_out == '0 && m_weekday_out == '0))
        else $error("error result with non-zero fields");

    // The final character rearms the position
    a_rearm: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_beat && s_last_byte) |=> (pos_reg == '0))
        else $error("position not rearmed after final character");

    // Position never passes the string length
    a_pos_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_W'(DATE_LEN))
        else $error("character position past string length");

    // A result only comes out of the last parse stage
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(b_vld_reg))
        else $error("result without a parsed string behind it");

endmodule

FILE: tb/http_date_parser_tb.sv
module http_date_parser_tb
    import hdp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // One parsed date as it leaves the block
    typedef struct packed {
        status_t     status;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  wday;
    } date_res_t;

    // Directed string, with its result typed in where it is obvious
    typedef struct {
        string     txt;
        bit        typed;
        date_res_t res;
    } date_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_last_byte;
    logic        m_valid;
    logic        m_ready;
    logic [3:0]  m_status;
    logic [13:0] m_year_out;
    logic [3:0]  m_month_out;
    logic [4:0]  m_day_out;
    logic [4:0]  m_hour_out;
    logic [5:0]  m_minute_out;
    logic [5:0]  m_second_out;
    logic [2:0]  m_weekday_out;

    http_date_parser u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_last_byte   (s_last_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_year_out    (m_year_out),
        .m_month_out   (m_month_out),
        .m_day_out     (m_day_out),
        .m_hour_out    (m_hour_out),
        .m_minute_out  (m_minute_out),
        .m_second_out  (m_second_out),
        .m_weekday_out (m_weekday_out)
    );

    string wd_txt [7]  = '{"Sun", "Mon", "Tue", "Wed", "Thu", "Fri", "Sat"};
    string mon_txt [12] = '{"Jan", "Feb", "Mar", "Apr", "May", "Jun",
                            "Jul", "Aug", "Sep", "Oct", "Nov", "Dec"};
    int days_in [12]  = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    int dow_base [12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};

    // Shadow of the character store and its fill count
    logic [7:0] date_buf [DATE_LEN];
    int         date_len = 0;

    date_res_t  pending_dates [$];
    int         mismatches = 0;
    int         burst_left = 0;

    date_row_t date_rows [$] = '{
        '{"Sun, 06 Nov 1994 08:49:37 GM", 1'b1, '{ST_SHORT, 0, 0, 0, 0, 0, 0, 0}},
        '{"Sun, 06 Nov 1994 08:49:37 GMT", 1'b1, '{ST_OK, 1994, 11, 6, 8, 49, 37, 0}},
        '{"Sat, 01 Jan 1583 00:00:00 GMT", 1'b1, '{ST_OK, 1583, 1, 1, 0, 0, 0, 6}},
        '{"Fri, 31 Dec 9999 23:59:59 GMT", 1'b1, '{ST_OK, 9999, 12, 31, 23, 59, 59, 5}},
        '{"Tue, 29 Feb 2000 12:00:00 GMT", 1'b0, '0},
        '{"Thu, 29 Feb 1900 12:00:00 GMT", 1'b1, '{ST_DAY, 0, 0, 0, 0, 0, 0, 0}},
        '{"Sun, 06 Nov 1994 08:49:37 GMT, plus trailing text", 1'b1,
          '{ST_OK, 1994, 11, 6, 8, 49, 37, 0}},
        '{"SunXX06XNovX1994X08X49X37XGMT", 1'b1, '{ST_OK, 1994, 11, 6, 8, 49, 37, 0}},
        '{"Sun, +6 Nov 1994 \t8: 9:-0 GMT", 1'b0, '0},
        '{"sun, 06 Nov 1994 08:49:37 GMT", 1'b1, '{ST_WDNAME, 0, 0, 0, 0, 0, 0, 0}},
        '{"Sun, 00 Nov 1994 08:49:37 GMT", 1'b1, '{ST_DAY, 0, 0, 0, 0, 0, 0, 0}},
        '{"Sun, 32 Nov 1994 08:49:37 GMT", 1'b1, '{ST_DAY, 0, 0, 0, 0, 0, 0, 0}},
        '{"Sun, -6 Nov 1994 08:49:37 GMT", 1'b1, '{ST_DAY, 0, 0, 0, 0, 0, 0, 0}},
        '{"Sun, 06 nov 1994 08:49:37 GMT", 1'b1, '{ST_MONTH, 0, 0, 0, 0, 0, 0, 0}},
        '{"Sun, 06 Nov 1582 08:49:37 GMT", 1'b1, '{ST_YEAR, 0, 0, 0, 0, 0, 0, 0}},
        '{"Sun, 06 Nov 19x4 08:49:37 GMT", 1'b1, '{ST_YEAR, 0, 0, 0, 0, 0, 0, 0}},
        '{"Mon, 06 Nov 1994 08:49:37 GMT", 1'b1, '{ST_MISMATCH, 0, 0, 0, 0, 0, 0, 0}},
        '{"Sun, 06 Nov 1994 24:49:37 GMT", 1'b1, '{ST_HOUR, 0, 0, 0, 0, 0, 0, 0}},
        '{"Sun, 06 Nov 1994 08:60:37 GMT", 1'b1, '{ST_MINUTE, 0, 0, 0, 0, 0, 0, 0}},
        '{"Sun, 06 Nov 1994 08:49:60 GMT", 1'b1, '{ST_SECOND, 0, 0, 0, 0, 0, 0, 0}},
        '{"Sun, 06 Nov 1994 08:49:-1 GMT", 1'b1, '{ST_SECOND, 0, 0, 0, 0, 0, 0, 0}},
        '{"Sun, 06 Nov 1994 08:49:37 UTC", 1'b1, '{ST_ZONE, 0, 0, 0, 0, 0, 0, 0}},
        '{"X", 1'b1, '{ST_SHORT, 0, 0, 0, 0, 0, 0, 0}}
    };

    function automatic bit is_dec(input logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic bit is_leap_yr(input int y);
        return (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
    endfunction

    // Gregorian day of the week, 0 for Sunday; month counts from 0
    function automatic int weekday_of(input int y, input int mo, input int d);
        int yy;
        yy = (mo < 2) ? y - 1 : y;
        return ((yy + yy / 4 - yy / 100 + yy / 400 + dow_base[mo] + d) % 7 + 7) % 7;
    endfunction

    // Index of the three-letter name at off, or -1
    function automatic int name_at(input int off, input bit months);
        string nm;
        int    i;
        for (i = 0; i < (months ? 12 : 7); i++) begin
            nm = months ? mon_txt[i] : wd_txt[i];
            if (date_buf[off] == nm[0] && date_buf[off + 1] == nm[1] &&
                date_buf[off + 2] == nm[2])
                return i;
        end
        return -1;
    endfunction

    // Two-character number with leading blank, plus or minus allowed
    function automatic bit two_digit(input int off, output int v);
        logic [7:0] a, b;
        a = date_buf[off];
        b = date_buf[off + 1];
        v = 0;
        if (!is_dec(b))
            return 1'b0;
        if (is_dec(a))
            v = (int'(a) - int'(CH_0)) * 10 + int'(b) - int'(CH_0);
        else if ((a >= CH_TAB && a <= CH_CR) || a == CH_SPACE || a == CH_PLUS)
            v = int'(b) - int'(CH_0);
        else if (a == CH_MINUS)
            v = int'(CH_0) - int'(b);
        else
            return 1'b0;
        return 1'b1;
    endfunction

    // Run the checks in order; the first one to fail names the status
    function automatic date_res_t decode_date();
        date_res_t r;
        int        wd, mo, d, y, h, mi, s, mlen, i;
        r = '0;
        r.status = ST_SHORT;
        if (date_len < DATE_LEN)
            return r;
        r.status = ST_WDNAME;
        wd = name_at(0, 1'b0);
        if (wd < 0)
            return r;
        r.status = ST_DAY;
        if (!two_digit(5, d) || d < 1 || d > 31)
            return r;
        r.status = ST_MONTH;
        mo = name_at(8, 1'b1);
        if (mo < 0)
            return r;
        r.status = ST_YEAR;
        y = 0;
        for (i = 12; i < 16; i++) begin
            if (!is_dec(date_buf[i]))
                return r;
            y = y * 10 + int'(date_buf[i]) - int'(CH_0);
        end
        if (y < int'(MIN_YEAR))
            return r;
        r.status = ST_DAY;
        mlen = (mo == 1 && is_leap_yr(y)) ? 29 : days_in[mo];
        if (d > mlen)
            return r;
        r.status = ST_MISMATCH;
        if (weekday_of(y, mo, d) != wd)
            return r;
        r.status = ST_HOUR;
        if (!two_digit(17, h) || h < 0 || h > 23)
            return r;
        r.status = ST_MINUTE;
        if (!two_digit(20, mi) || mi < 0 || mi > 59)
            return r;
        r.status = ST_SECOND;
        if (!two_digit(23, s) || s < 0 || s > 59)
            return r;
        r.status = ST_ZONE;
        if ({date_buf[26], date_buf[27], date_buf[28]} != ZONE_GMT)
            return r;
        r.status = ST_OK;
        r.year   = 14'(y);
        r.month  = 4'(mo + 1);
        r.day    = 5'(d);
        r.hour   = 5'(h);
        r.minute = 6'(mi);
        r.second = 6'(s);
        r.wday   = 3'(wd);
        return r;
    endfunction

    // Store one character; on the final one parse and rearm
    function automatic bit take_char(input logic [7:0] c, input bit last,
                                     output date_res_t r);
        if (date_len < DATE_LEN) begin
            date_buf[date_len] = c;
            date_len++;
        end
        if (!last)
            return 1'b0;
        r = decode_date();
        date_len = 0;
        return 1'b1;
    endfunction

    task automatic note_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Drive one character beat, idling at burst boundaries, and predict on acceptance
    task automatic push_char(input logic [7:0] c, input bit last, input bit typed,
                             input date_res_t want);
        int        gap;
        date_res_t got;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 60);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        burst_left--;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= c;
        s_last_byte <= last;
        do @(posedge aclk); while (!s_ready);
        if (take_char(c, last, got))
            pending_dates.push_back(typed ? want : got);
    endtask

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // Receiver: switch in turn between several stall patterns
    initial begin : result_side
        int cyc;
        m_ready = 1'b0;
        cyc = 0;
        forever begin
            @(negedge aclk);
            cyc++;
            case ((cyc / 250) % 4)
                0: m_ready <= 1'b1;
                1: m_ready <= $urandom_range(0, 9) < 6;
                2: m_ready <= (cyc % 9) < 5;
                default: m_ready <= ((cyc / 17) % 3) != 0;
            endcase
        end
    end

    // Compare each result beat with the oldest pending date
    always @(posedge aclk) begin
        date_res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_dates.size() == 0) begin
                note_mismatch("result with nothing pending, status", m_status, 0);
            end else begin
                want = pending_dates.pop_front();
                if (m_status !== want.status)
                    note_mismatch("status", m_status, want.status);
                if (m_year_out !== want.year)
                    note_mismatch("year", m_year_out, want.year);
                if (m_month_out !== want.month)
                    note_mismatch("month", m_month_out, want.month);
                if (m_day_out !== want.day)
                    note_mismatch("day", m_day_out, want.day);
                if (m_hour_out !== want.hour)
                    note_mismatch("hour", m_hour_out, want.hour);
                if (m_minute_out !== want.minute)
                    note_mismatch("minute", m_minute_out, want.minute);
                if (m_second_out !== want.second)
                    note_mismatch("second", m_second_out, want.second);
                if (m_weekday_out !== want.wday)
                    note_mismatch("weekday", m_weekday_out, want.wday);
            end
        end
    end

    initial begin : char_side
        logic [7:0] chars [$];
        string      txt;
        date_res_t  none;
        int         r, k, y, mo, d, h, mi, s, wd, mlen, pos, pick, rand_chars;

        none        = '0;
        rand_chars  = 0;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data_byte = '0;
        s_last_byte = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed strings
        foreach (date_rows[r]) begin
            for (k = 0; k < date_rows[r].txt.len(); k++)
                push_char(date_rows[r].txt[k], k == date_rows[r].txt.len() - 1,
                          date_rows[r].typed, date_rows[r].res);
        end

        // Random strings: mostly well-formed dates, some damaged, some noise
        while (rand_chars < 1350) begin
            chars.delete();
            if ($urandom_range(0, 99) < 8) begin
                repeat ($urandom_range(1, 40))
                    chars.push_back(8'($urandom_range(0, 255)));
            end else begin
                case ($urandom_range(0, 9))
                    0: y = $urandom_range(1583, 1600);
                    1: y = $urandom_range(9990, 9999);
                    2: y = $urandom_range(0, 1582);
                    3, 4, 5, 6: y = $urandom_range(1900, 2100);
                    default: y = $urandom_range(1583, 9999);
                endcase
                mo   = $urandom_range(0, 11);
                mlen = (mo == 1 && is_leap_yr(y)) ? 29 : days_in[mo];
                d    = ($urandom_range(0, 19) == 0) ? $urandom_range(mlen + 1, 39)
                                                    : $urandom_range(1, mlen);
                h    = ($urandom_range(0, 19) == 0) ? $urandom_range(24, 99)
                                                    : $urandom_range(0, 23);
                mi   = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 99)
                                                    : $urandom_range(0, 59);
                s    = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 99)
                                                    : $urandom_range(0, 59);
                wd   = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 6)
                                                    : weekday_of(y, mo, d);
                txt = $sformatf("%s, %02d %s %04d %02d:%02d:%02d GMT",
                                wd_txt[wd], d, mon_txt[mo], y, h, mi, s);
                for (k = 0; k < txt.len(); k++)
                    chars.push_back(txt[k]);
                if ($urandom_range(0, 32) == 0) begin
                    for (k = 26; k < 29; k++)
                        chars[k] = 8'($urandom_range(0, 255));
                end
                // Damage or bend the string now and then
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    chars[$urandom_range(0, 28)] = 8'($urandom_range(0, 255));
                end else if (pick < 20) begin
                    case ($urandom_range(0, 3))
                        0: pos = 5;
                        1: pos = 17;
                        2: pos = 20;
                        default: pos = 23;
                    endcase
                    k = $urandom_range(0, 7);
                    chars[pos] = (k < 5) ? 8'(int'(CH_TAB) + k)
                               : (k == 5) ? CH_SPACE : (k == 6) ? CH_PLUS : CH_MINUS;
                end else if (pick < 25) begin
                    k = $urandom_range(1, 28);
                    while (chars.size() > k)
                        void'(chars.pop_back());
                end else if (pick < 30) begin
                    repeat ($urandom_range(1, 12))
                        chars.push_back(8'($urandom_range(0, 255)));
                end
            end
            foreach (chars[k])
                push_char(chars[k], k == chars.size() - 1, 1'b0, none);
            rand_chars += chars.size();
        end

        @(negedge aclk);
        s_valid     <= 1'b0;
        s_last_byte <= 1'b0;

        // Drain, then keep watching for stray beats
        while (pending_dates.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/hdp_pkg.sv
hw/rtl/http_date_parser.sv
tb/http_date_parser_tb.sv
